@@ rtl/edit_distance_engine_defines.svh @@
// ---------------------------------------------------------------------------
// Edit distance engine assertion macros
// Concurrent assertion helpers used by the engine datapath.
// ---------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Checks that an expression holds at every clock edge outside reset.
`define EDE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("edit distance engine: invariant violated");
// Checks that a consequent holds in the same cycle as its antecedent.
`define EDE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edit distance engine: implication violated");
`else
`define EDE_ASSERT_ALWAYS(label, clk, rst, expr)
`define EDE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/ede_pkg.sv @@
// ---------------------------------------------------------------------------
// Edit distance engine package
// Sizes, field types, input kinds and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package ede_pkg;

   // Longest string that is kept; longer strings drop their extra characters.
   localparam int MAX_LEN = 64;
   // Counts and row values run from 0 to MAX_LEN.
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int SYM_W   = 8;
   localparam int KIND_W  = 2;
   localparam int OUT_W   = 7;
   localparam int RSP_FIELDS_W = 3 * OUT_W + 1;
   localparam int RSP_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [OUT_W-1:0]  out_type;

   localparam count_type MAX_CNT = count_type'(MAX_LEN);

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRST  = 2'd0,
      KIND_SECOND = 2'd1,
      KIND_END    = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      logic load_first;
      logic set_overflow;
      logic start_walk;
      logic issue;
      logic read_final;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic first_full;
      logic second_full;
      logic second_started;
      logic first_empty;
      logic last_issue;
      logic slot_free;
   } status_type;

endpackage

@@ rtl/edit_distance_engine.sv @@
// ---------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between two byte strings streamed one character a time.
// ---------------------------------------------------------------------------
// Send the first string as kind 0 items, then the second string as kind 1
// items, then one kind 2 item; the kind 2 item returns the distance, both
// lengths and an overflow flag, and clears the engine for the next pair.
// Up to 64 characters per string are kept; extra ones are dropped and set the
// overflow flag, and first-string characters sent after the second string has
// started are ignored. The engine takes one item at a time. A kind 1 item
// makes the row update walk the stored row memory one cell per cycle
// through its single read port, after a start step and followed by a drain
// step that retires the last cell; while the first string is empty there is
// no walk. A kind 2 item reads the final row cell and then loads the result
// register, waiting between the two only while an earlier result has not yet
// been taken. New items are accepted while a result waits in its register.
// ---------------------------------------------------------------------------
module edit_distance_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [7:0] symbol
   input  logic [1:0]                req_tuser,  // [1:0] kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [6:0] distance, [13:7] first_length, [20:14] second_length,
   // [21] overflow, [23:22] zero
   output logic [ede_pkg::RSP_W-1:0] rsp_tdata
);

   // The controller and the datapath talk only through these two structs.
   ede_pkg::cmd_type    cmd;
   ede_pkg::status_type status;

   ede_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .kind      (ede_pkg::kind_type'(req_tuser)),
      .status    (status),
      .cmd       (cmd)
   );

   ede_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .symbol    (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

@@ rtl/ede_datapath.sv @@
// ---------------------------------------------------------------------------
// Edit distance engine datapath
// String and row memories, the cell update stage, counters and result slot.
// ---------------------------------------------------------------------------
`include "edit_distance_engine_defines.svh"

module ede_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ede_pkg::sym_type          symbol,
   input  ede_pkg::cmd_type          cmd,
   output ede_pkg::status_type       status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ede_pkg::RSP_W-1:0] rsp_data
);

   // Memories: the stored first string and row cells 1..MAX_LEN. Row cell 0
   // always equals the second-string count, so it lives in that counter.
   ede_pkg::sym_type   fs_mem [0:ede_pkg::MAX_LEN-1];
   ede_pkg::count_type dp_mem [1:ede_pkg::MAX_LEN];

   ede_pkg::count_type first_count_ff, first_count_in;
   ede_pkg::count_type second_count_ff, second_count_in;
   logic               overflow_ff, overflow_in;
   ede_pkg::sym_type   sym_ff, sym_in;
   logic               row_valid_ff, row_valid_in;
   ede_pkg::count_type diag_ff, diag_in;
   ede_pkg::count_type left_ff, left_in;
   ede_pkg::count_type idx_ff, idx_in;
   logic               pipe_valid_ff, pipe_valid_in;
   ede_pkg::count_type pipe_idx_ff, pipe_idx_in;
   ede_pkg::sym_type   fs_rd_ff;
   ede_pkg::count_type dp_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   ede_pkg::out_type   dist_ff, dist_in;
   ede_pkg::out_type   flen_ff, flen_in;
   ede_pkg::out_type   slen_ff, slen_in;
   logic               rovf_ff, rovf_in;

   ede_pkg::count_type dp_raddr;
   ede_pkg::addr_type  fs_raddr;
   ede_pkg::count_type up;
   ede_pkg::count_type min_lu;
   ede_pkg::count_type min_all;
   ede_pkg::count_type cell_value;
   ede_pkg::count_type final_value;
   logic               counts_ok;
   logic               issue_ok;

   assign dp_raddr = cmd.read_final ? first_count_ff : idx_ff;
   assign fs_raddr = ede_pkg::addr_type'(idx_ff - ede_pkg::count_type'(1));

   // Before the first second-string character the row is 0..N, so an
   // unwritten cell reads as its own index.
   assign up         = row_valid_ff ? dp_rd_ff : pipe_idx_ff;
   assign min_lu     = (up < left_ff) ? up : left_ff;
   assign min_all    = (diag_ff < min_lu) ? diag_ff : min_lu;
   assign cell_value = (fs_rd_ff == sym_ff) ? diag_ff
                                            : min_all + ede_pkg::count_type'(1);

   always_comb begin
      priority if (first_count_ff == '0) begin
         final_value = second_count_ff;
      end else if (second_count_ff == '0) begin
         final_value = first_count_ff;
      end else begin
         final_value = dp_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_first) begin
         fs_mem[first_count_ff[ede_pkg::ADDR_W-1:0]] <= symbol;
      end
      if (pipe_valid_ff) begin
         dp_mem[pipe_idx_ff] <= cell_value;
      end
      if (cmd.issue) begin
         fs_rd_ff <= fs_mem[fs_raddr];
      end
      if (cmd.issue || cmd.read_final) begin
         dp_rd_ff <= dp_mem[dp_raddr];
      end
   end

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      sym_in          = sym_ff;
      row_valid_in    = row_valid_ff;
      diag_in         = diag_ff;
      left_in         = left_ff;
      idx_in          = idx_ff;
      pipe_valid_in   = 1'b0;
      pipe_idx_in     = pipe_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      dist_in         = dist_ff;
      flen_in         = flen_ff;
      slen_in         = slen_ff;
      rovf_in         = rovf_ff;

      if (cmd.load_first) begin
         first_count_in = first_count_ff + ede_pkg::count_type'(1);
      end
      if (cmd.set_overflow) begin
         overflow_in = 1'b1;
      end
      if (cmd.start_walk) begin
         second_count_in = second_count_ff + ede_pkg::count_type'(1);
         row_valid_in    = (second_count_ff != '0);
         sym_in          = symbol;
         diag_in         = second_count_ff;
         left_in         = second_count_ff + ede_pkg::count_type'(1);
         idx_in          = ede_pkg::count_type'(1);
      end else if (pipe_valid_ff) begin
         diag_in = up;
         left_in = cell_value;
      end
      if (cmd.issue) begin
         idx_in        = idx_ff + ede_pkg::count_type'(1);
         pipe_valid_in = 1'b1;
         pipe_idx_in   = idx_ff;
      end
      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         dist_in         = ede_pkg::out_type'(final_value);
         flen_in         = ede_pkg::out_type'(first_count_ff);
         slen_in         = ede_pkg::out_type'(second_count_ff);
         rovf_in         = overflow_ff;
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         pipe_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         pipe_valid_ff   <= pipe_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      row_valid_ff <= row_valid_in;
      diag_ff      <= diag_in;
      left_ff      <= left_in;
      idx_ff       <= idx_in;
      pipe_idx_ff  <= pipe_idx_in;
      dist_ff      <= dist_in;
      flen_ff      <= flen_in;
      slen_ff      <= slen_in;
      rovf_ff      <= rovf_in;
   end

   assign status.first_full     = (first_count_ff == ede_pkg::MAX_CNT);
   assign status.second_full    = (second_count_ff == ede_pkg::MAX_CNT);
   assign status.second_started = (second_count_ff != '0);
   assign status.first_empty    = (first_count_ff == '0);
   assign status.last_issue     = (idx_ff == first_count_ff);
   assign status.slot_free      = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = {{(ede_pkg::RSP_W - ede_pkg::RSP_FIELDS_W){1'b0}},
                       rovf_ff, slen_ff, flen_ff, dist_ff};

   assign counts_ok = (first_count_ff <= ede_pkg::MAX_CNT) &&
                      (second_count_ff <= ede_pkg::MAX_CNT);
   assign issue_ok  = (idx_ff != '0) && (idx_ff <= first_count_ff);

   `EDE_ASSERT_ALWAYS(a_counts_bounded, clock, reset, counts_ok)
   `EDE_ASSERT_IMPLY(a_issue_in_row, clock, reset, cmd.issue, issue_ok)
   `EDE_ASSERT_IMPLY(a_cell_after_start, clock, reset, pipe_valid_ff, second_count_ff != '0)
   `EDE_ASSERT_IMPLY(a_first_frozen, clock, reset, cmd.load_first, second_count_ff == '0)

endmodule

@@ rtl/ede_controller.sv @@
// ---------------------------------------------------------------------------
// Edit distance engine controller
// Decodes input items and sequences the row walk and the result hand-off.
// ---------------------------------------------------------------------------
module ede_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ede_pkg::kind_type   kind,
   input  ede_pkg::status_type status,
   output ede_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  ede_pkg::KIND_FIRST: begin
                     // Once the second string has started the row is fixed.
                     if (!status.second_started) begin
                        cmd.set_overflow = status.first_full;
                        cmd.load_first   = !status.first_full;
                     end
                  end
                  ede_pkg::KIND_SECOND: begin
                     if (status.second_full) begin
                        cmd.set_overflow = 1'b1;
                     end else begin
                        cmd.start_walk = 1'b1;
                        if (!status.first_empty) begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  ede_pkg::KIND_END: begin
                     cmd.read_final = 1'b1;
                     state_in       = ST_FINISH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_FINISH: begin
            if (status.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
